// File: sv/acs_pkg.sv
package acs_pkg;

    // Scan geometry.
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    // Conversion of a 16-bit code to microvolts: floor(code * UV_FULL_SCALE / CODE_SPAN).
    localparam int UV_FULL_SCALE = 2500000;
    localparam int CODE_SPAN     = 65535;
    localparam int PROD_W        = 38;
    localparam int QEST_W        = 23;
    localparam int REM_W         = 18;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_CFG_OVERWRITE    = 4'd0,
        REG_INPUT_MODE       = 4'd1,
        REG_BANDWIDTH_FULL   = 4'd2,
        REG_REFERENCE_SELECT = 4'd3,
        REG_SEQUENCER_MODE   = 4'd4,
        REG_READBACK_DISABLE = 4'd5,
        REG_DWELL_LIMIT      = 4'd6,
        REG_CHANNELS_USED    = 4'd7
    } t_reg_idx;

    // Request kinds.
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] rx_word;
        logic [3:0]  query_channel;
    } t_req;

    typedef struct packed {
        logic [15:0] tx_word;
        logic        sample_valid;
        logic [2:0]  sample_channel;
        logic [15:0] sample_code;
        logic [21:0] sample_microvolts;
        logic [15:0] read_code;
        logic [21:0] read_microvolts;
    } t_rsp;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic        is_read;
        logic [15:0] tx_word;
        logic        sample_valid;
        logic [2:0]  sample_channel;
        logic [15:0] code;
    } t_job;

    // Low three bits of a channel number, zero-extended when the channel is narrower.
    function automatic logic [2:0] low3(input logic [CH_W-1:0] c);
        logic [CH_W+2:0] e;
        e = {3'b000, c};
        return e[2:0];
    endfunction

endpackage

// File: sv/adc_channel_scan_sequencer.sv
// A word accepted at the input passes through the queue, the multiply stage, the quotient
// stage and the output register before it appears on o_valid.
// Throughput: one word per clock while i_stall is low; the back end is fully pipelined and
// the four-word queue lets the input keep flowing while the output side stalls briefly.
// Reset (synchronous, active low): registers return to their defaults, channel 0,
// dwell count 0, every stored channel code 0, queue and pipeline empty.
module adc_channel_scan_sequencer
    import acs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_stall,
    output t_rsp       o_rsp
);

    // The front end owns the configuration registers, the scan position, the dwell
    // counter and the per-channel code store. It classifies each word as a scan frame
    // or a read request, settles all state changes at acceptance, and hands a compact
    // job to the queue. Because the store is updated at acceptance, a read request that
    // follows a scan frame always sees that frame's sample.
    logic fifo_full;
    logic push;
    t_job push_job;

    // Only codes are stored; microvolts are recomputed from the code in the back end,
    // which gives the same value as keeping a separate voltage table.
    logic pop;
    logic nonempty;
    t_job head_job;

    acs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_req      (i_req),
        .i_full     (fifo_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The input side stalls only when the queue is full, independent of i_valid.
    assign o_stall = fifo_full;

    acs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_full     (fifo_full),
        .o_nonempty (nonempty),
        .o_job      (head_job)
    );

    // The back end scales the code to microvolts: one 16x22 multiply, then a
    // reciprocal estimate of the division by 65535 with a small correction, and
    // finally assembles the result word in the output register.
    acs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

endmodule

// File: sv/acs_front.sv
module acs_front
    import acs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    input  t_req        i_req,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic             r_cfg_overwrite;
    logic [2:0]       r_input_mode;
    logic             r_bandwidth_full;
    logic [2:0]       r_reference_select;
    logic [1:0]       r_sequencer_mode;
    logic             r_readback_disable;
    logic [7:0]       r_dwell_limit;
    logic [3:0]       r_channels_used;

    logic [CH_W-1:0]  r_chan;
    logic [8:0]       r_dwell;
    logic [15:0]      r_codes [MAX_CHANNELS];

    logic             accept;
    logic             is_read;
    logic [CNT_W-1:0] active_n;
    logic [CH_W-1:0]  wrap_chan;
    logic [CH_W-1:0]  n_chan;
    logic [8:0]       dwell_inc;
    logic [8:0]       n_dwell;
    logic             store;
    logic             q_in_range;
    logic [15:0]      q_code;

    // Effective channel count: zero acts as one, large values clamp to the maximum.
    function automatic logic [CNT_W-1:0] active_count(input logic [3:0] used);
        logic [CNT_W+3:0] u;
        u = {{CNT_W{1'b0}}, used};
        if (used == 4'd0) begin
            return CNT_W'(1);
        end
        if (u > (CNT_W + 4)'(MAX_CHANNELS)) begin
            return CNT_W'(MAX_CHANNELS);
        end
        return u[CNT_W-1:0];
    endfunction

    // (chan + 1) mod n for narrow operands: subtract the largest multiple of n that fits.
    function automatic logic [CH_W-1:0] wrap_next(input logic [CH_W-1:0] chan,
                                                 input logic [CNT_W-1:0] n);
        logic [2*CNT_W-1:0] a;
        logic [2*CNT_W-1:0] m;
        logic [2*CNT_W-1:0] rem;
        a   = (2*CNT_W)'(chan) + (2*CNT_W)'(1);
        rem = a;
        for (int k = 1; k <= MAX_CHANNELS; k++) begin
            m = (2*CNT_W)'(k) * (2*CNT_W)'(n);
            if (m <= a) begin
                rem = a - m;
            end
        end
        return rem[CH_W-1:0];
    endfunction

    assign accept  = i_valid && !i_full;
    assign is_read = (i_req.req_type == REQ_READ);
    assign o_push  = accept;

    always_comb begin
        active_n   = active_count(r_channels_used);
        wrap_chan  = wrap_next(r_chan, active_n);
        dwell_inc  = r_dwell + 9'd1;
        if (dwell_inc > {1'b0, r_dwell_limit}) begin
            n_dwell = 9'd0;
            n_chan  = wrap_chan;
        end else begin
            n_dwell = dwell_inc;
            n_chan  = r_chan;
        end
        store      = (n_chan != r_chan);
        q_in_range = ({1'b0, i_req.query_channel} < 5'(MAX_CHANNELS));
        q_code     = q_in_range ? r_codes[i_req.query_channel[CH_W-1:0]] : 16'd0;
    end

    always_comb begin
        o_job = '0;
        if (is_read) begin
            o_job.is_read = 1'b1;
            o_job.code    = q_code;
        end else begin
            o_job.tx_word = {r_cfg_overwrite, r_input_mode, low3(n_chan), r_bandwidth_full,
                             r_reference_select, r_sequencer_mode, r_readback_disable,
                             2'b00};
            if (store) begin
                o_job.sample_valid   = 1'b1;
                o_job.sample_channel = low3(r_chan);
                o_job.code           = i_req.rx_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_overwrite    <= 1'b1;
            r_input_mode       <= 3'd7;
            r_bandwidth_full   <= 1'b0;
            r_reference_select <= 3'd0;
            r_sequencer_mode   <= 2'd0;
            r_readback_disable <= 1'b1;
            r_dwell_limit      <= 8'd2;
            r_channels_used    <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CFG_OVERWRITE:    r_cfg_overwrite    <= i_cfg_data[0];
                REG_INPUT_MODE:       r_input_mode       <= i_cfg_data[2:0];
                REG_BANDWIDTH_FULL:   r_bandwidth_full   <= i_cfg_data[0];
                REG_REFERENCE_SELECT: r_reference_select <= i_cfg_data[2:0];
                REG_SEQUENCER_MODE:   r_sequencer_mode   <= i_cfg_data[1:0];
                REG_READBACK_DISABLE: r_readback_disable <= i_cfg_data[0];
                REG_DWELL_LIMIT:      r_dwell_limit      <= i_cfg_data;
                REG_CHANNELS_USED:    r_channels_used    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_dwell <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_codes[CH_W'(i)] <= 16'd0;
            end
        end else if (accept && !is_read) begin
            r_chan  <= n_chan;
            r_dwell <= n_dwell;
            if (store) begin
                r_codes[r_chan] <= i_req.rx_word;
            end
        end
    end

    a_store_moves_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_read && store) |=> (r_chan != $past(r_chan)))
        else $error("sample stored without a channel change");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_read) |=> ($stable(r_chan) && $stable(r_dwell)))
        else $error("read request changed the scan state");

endmodule

// File: sv/acs_fifo.sv
module acs_fifo
    import acs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_job
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_full     = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FIFO_CW'(FIFO_DEPTH)) || i_pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from an empty queue");

endmodule

// File: sv/acs_back.sv
module acs_back
    import acs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_nonempty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic              r_s1_v;
    t_job              r_s1_job;
    logic [PROD_W-1:0] r_s1_prod;

    logic              r_s2_v;
    t_job              r_s2_job;
    logic [QEST_W-1:0] r_s2_qest;
    logic [REM_W-1:0]  r_s2_rem;

    logic              r_out_v;
    t_rsp              r_out;

    logic              out_adv;
    logic              s2_adv;
    logic              s1_adv;
    logic [PROD_W:0]   sum;
    logic [QEST_W-1:0] qest;
    logic [PROD_W:0]   rem_full;
    logic [QEST_W-1:0] q_fix;
    logic [21:0]       uv;
    t_rsp              n_out;

    assign out_adv = !r_out_v || !i_stall;
    assign s2_adv  = !r_s2_v || out_adv;
    assign s1_adv  = !r_s1_v || s2_adv;
    assign o_pop   = i_nonempty && s1_adv;

    // Quotient estimate by p / 65535 ~ (p + p / 65536) / 65536, never above the true value.
    always_comb begin
        sum      = {1'b0, r_s1_prod} + (PROD_W + 1)'(r_s1_prod >> 16);
        qest     = sum[PROD_W:16];
        rem_full = {1'b0, r_s1_prod} - {qest, 16'h0000} + (PROD_W + 1)'(qest);
    end

    always_comb begin
        q_fix = r_s2_qest;
        if (r_s2_rem >= REM_W'(CODE_SPAN)) begin
            q_fix = q_fix + QEST_W'(1);
        end
        if (r_s2_rem >= REM_W'(2 * CODE_SPAN)) begin
            q_fix = q_fix + QEST_W'(1);
        end
        uv = q_fix[21:0];

        n_out = '0;
        if (r_s2_job.is_read) begin
            n_out.read_code       = r_s2_job.code;
            n_out.read_microvolts = uv;
        end else begin
            n_out.tx_word           = r_s2_job.tx_word;
            n_out.sample_valid      = r_s2_job.sample_valid;
            n_out.sample_channel    = r_s2_job.sample_channel;
            n_out.sample_code       = r_s2_job.code;
            n_out.sample_microvolts = uv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_job  <= i_job;
            r_s1_prod <= PROD_W'(i_job.code) * PROD_W'(UV_FULL_SCALE);
        end
        if (s2_adv) begin
            r_s2_job  <= r_s1_job;
            r_s2_qest <= qest;
            r_s2_rem  <= rem_full[REM_W-1:0];
        end
        if (out_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= i_nonempty;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
            if (out_adv) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_s2_rem < REM_W'(3 * CODE_SPAN)))
        else $error("quotient estimate off by more than two");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import acs_pkg::*;

    // Clock and reset. Reset is held low at the start of the run and never again.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration write port. It is only touched while the sequencer is idle.
    logic       i_cfg_we   = 1'b0;
    logic [3:0] i_cfg_idx  = '0;
    logic [7:0] i_cfg_data = '0;

    // Request and response channels.
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req   = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    adc_channel_scan_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers, kept at the register widths.
    logic       sh_cfg_ow;
    logic [2:0] sh_in_mode;
    logic       sh_bw_full;
    logic [2:0] sh_ref_sel;
    logic [1:0] sh_seq_mode;
    logic       sh_rb_dis;
    logic [7:0] sh_dwell_lim;
    logic [3:0] sh_chan_cfg;

    // Shadow copy of the scan state and the per-channel sample store.
    int          scan_ch;
    logic [8:0]  dwell_cnt;
    logic [15:0] stored_code [MAX_CHANNELS];
    logic [21:0] stored_uv   [MAX_CHANNELS];

    // Words waiting to be sent, and the responses the accepted words must produce.
    t_req req_backlog [$];
    t_rsp rsp_due     [$];

    int mismatches = 0;

    function automatic void shadow_reset();
        sh_cfg_ow    = 1'b1;
        sh_in_mode   = 3'd7;
        sh_bw_full   = 1'b0;
        sh_ref_sel   = 3'd0;
        sh_seq_mode  = 2'd0;
        sh_rb_dis    = 1'b1;
        sh_dwell_lim = 8'd2;
        sh_chan_cfg  = 4'd8;
        scan_ch      = 0;
        dwell_cnt    = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            stored_code[CH_W'(k)] = '0;
            stored_uv[CH_W'(k)]   = '0;
        end
    endfunction

    // Mirrors a register write; indexes past the last register fall through untouched.
    function automatic void shadow_reg_write(input logic [3:0] idx, input logic [7:0] d);
        case (idx)
            REG_CFG_OVERWRITE:    sh_cfg_ow    = d[0];
            REG_INPUT_MODE:       sh_in_mode   = d[2:0];
            REG_BANDWIDTH_FULL:   sh_bw_full   = d[0];
            REG_REFERENCE_SELECT: sh_ref_sel   = d[2:0];
            REG_SEQUENCER_MODE:   sh_seq_mode  = d[1:0];
            REG_READBACK_DISABLE: sh_rb_dis    = d[0];
            REG_DWELL_LIMIT:      sh_dwell_lim = d;
            REG_CHANNELS_USED:    sh_chan_cfg  = d[3:0];
            default: ;
        endcase
    endfunction

    // Works out the response to one accepted word and advances the shadow state.
    function automatic t_rsp sequence_frame(input t_req rq);
        t_rsp            r;
        int              n_act;
        int              old_ch;
        int              nxt_ch;
        logic [8:0]      cnt;
        longint unsigned prod;
        logic [21:0]     uv;
        r = '0;
        if (rq.req_type == REQ_READ) begin
            // A query past the last channel reads back zeros.
            if (int'(rq.query_channel) < MAX_CHANNELS) begin
                r.read_code       = stored_code[rq.query_channel[CH_W-1:0]];
                r.read_microvolts = stored_uv[rq.query_channel[CH_W-1:0]];
            end
        end else begin
            // A channel count of zero scans one channel; a count past the top is clamped.
            n_act = int'(sh_chan_cfg);
            if (n_act == 0)
                n_act = 1;
            if (n_act > MAX_CHANNELS)
                n_act = MAX_CHANNELS;
            old_ch = scan_ch;
            nxt_ch = (old_ch + 1) % n_act;
            cnt    = dwell_cnt + 9'd1;
            if (cnt > {1'b0, sh_dwell_lim}) begin
                dwell_cnt = '0;
            end else begin
                dwell_cnt = cnt;
                nxt_ch    = old_ch;
            end
            r.tx_word = {sh_cfg_ow, sh_in_mode, 3'(nxt_ch), sh_bw_full,
                         sh_ref_sel, sh_seq_mode, sh_rb_dis, 2'b00};
            // Leaving a channel stores this frame's read word as that channel's sample.
            if (old_ch != nxt_ch) begin
                prod = longint'(rq.rx_word) * longint'(UV_FULL_SCALE);
                uv   = 22'(prod / longint'(CODE_SPAN));
                stored_code[CH_W'(old_ch)] = rq.rx_word;
                stored_uv[CH_W'(old_ch)]   = uv;
                r.sample_valid       = 1'b1;
                r.sample_channel     = 3'(old_ch);
                r.sample_code        = rq.rx_word;
                r.sample_microvolts  = uv;
            end
            scan_ch = nxt_ch;
        end
        return r;
    endfunction

    // Sender. It works in bursts of random length separated by random gaps, and
    // holds the word steady for as long as the sequencer stalls it. The expected
    // response is computed at the edge where the word is accepted.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rsp_due.push_back(sequence_frame(i_req));
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    i_req   <= req_backlog.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        // Now and then a long burst with no gaps at all.
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver. Every accepted response is compared field by field with the oldest
    // expectation. The stall pattern switches between free running, random stalls,
    // long stall stretches and a toggling stall.
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (rsp_due.size() == 0) begin
                    $error("response word with no expectation waiting");
                    mismatches++;
                end else begin
                    want = rsp_due.pop_front();
                    check_field("tx_word", want.tx_word, o_rsp.tx_word);
                    check_field("sample_valid", want.sample_valid, o_rsp.sample_valid);
                    check_field("sample_channel", want.sample_channel, o_rsp.sample_channel);
                    check_field("sample_code", want.sample_code, o_rsp.sample_code);
                    check_field("sample_microvolts", want.sample_microvolts,
                                o_rsp.sample_microvolts);
                    check_field("read_code", want.read_code, o_rsp.read_code);
                    check_field("read_microvolts", want.read_microvolts,
                                o_rsp.read_microvolts);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        i_stall <= 1'b1;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 20);
                        i_stall <= 1'b1;
                    end else begin
                        i_stall <= 1'b0;
                    end
                end
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // One register write: the port is raised for a single edge.
    task automatic write_reg(input logic [3:0] idx, input logic [7:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        shadow_reg_write(idx, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_cfg(input logic [7:0] ow, input logic [7:0] mode,
                             input logic [7:0] bw, input logic [7:0] rsel,
                             input logic [7:0] seq, input logic [7:0] rb,
                             input logic [7:0] dwell, input logic [7:0] chans);
        write_reg(REG_CFG_OVERWRITE, ow);
        write_reg(REG_INPUT_MODE, mode);
        write_reg(REG_BANDWIDTH_FULL, bw);
        write_reg(REG_REFERENCE_SELECT, rsel);
        write_reg(REG_SEQUENCER_MODE, seq);
        write_reg(REG_READBACK_DISABLE, rb);
        write_reg(REG_DWELL_LIMIT, dwell);
        write_reg(REG_CHANNELS_USED, chans);
    endtask

    // A write to an index past the last register must leave everything as it was.
    task automatic write_unknown_reg();
        write_reg(4'($urandom_range(int'(REG_CHANNELS_USED) + 1, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    // Sampled after the edge has settled, so a word driven at this edge is seen.
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || i_valid || rsp_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Directed words; the fields that the word's kind ignores carry random values.
    task automatic queue_scan(input logic [15:0] code);
        t_req rq;
        rq.req_type      = REQ_SCAN;
        rq.rx_word       = code;
        rq.query_channel = 4'($urandom_range(0, 15));
        req_backlog.push_back(rq);
    endtask

    task automatic queue_read(input logic [3:0] ch);
        t_req rq;
        rq.req_type      = REQ_READ;
        rq.rx_word       = 16'($urandom_range(0, 65535));
        rq.query_channel = ch;
        req_backlog.push_back(rq);
    endtask

    task automatic queue_random(input int n, input int read_pct);
        t_req rq;
        repeat (n) begin
            rq.req_type = ($urandom_range(0, 99) < read_pct) ? REQ_READ : REQ_SCAN;
            case ($urandom_range(0, 7))
                0:       rq.rx_word = 16'h0000;
                1:       rq.rx_word = 16'hFFFF;
                default: rq.rx_word = 16'($urandom_range(0, 65535));
            endcase
            // Mostly queries of real channels, some past the last one.
            rq.query_channel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(0, 7));
            req_backlog.push_back(rq);
        end
    endtask

    initial begin
        shadow_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: three frames per channel over eight channels. The first two
        // channels are left with full scale and zero, then the store is read back,
        // including queries past the last channel.
        queue_scan(16'h0000);
        queue_scan(16'h1234);
        queue_scan(16'hFFFF);
        queue_scan(16'h0001);
        queue_scan(16'h8000);
        queue_scan(16'h0000);
        queue_read(4'd0);
        queue_read(4'd1);
        queue_read(4'd2);
        queue_read(4'd8);
        queue_read(4'd15);

        // Every configuration field at its top value, with a long dwell.
        wait_idle();
        write_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd200, 8'd8);
        repeat (6) queue_scan(16'($urandom_range(0, 65535)));

        // The dwell limit drops below the count already reached, so the next frame
        // moves on at once.
        wait_idle();
        write_reg(REG_DWELL_LIMIT, 8'd3);
        queue_scan(16'hFFFF);

        // The channel count drops below the current channel; the advance wraps
        // modulo the new count.
        wait_idle();
        write_reg(REG_DWELL_LIMIT, 8'd0);
        write_reg(REG_CHANNELS_USED, 8'd2);
        write_unknown_reg();
        queue_scan(16'h7FFF);
        queue_scan(16'h8001);

        // All fields at zero and a single channel: after one wrap it never moves.
        wait_idle();
        write_cfg(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1);
        repeat (3) queue_scan(16'($urandom_range(0, 65535)));

        // A channel count of zero behaves as one.
        wait_idle();
        write_reg(REG_CHANNELS_USED, 8'd0);
        repeat (2) queue_scan(16'($urandom_range(0, 65535)));

        // A channel count past the top is clamped to the full set.
        wait_idle();
        write_reg(REG_CHANNELS_USED, 8'hFF);
        repeat (2) queue_scan(16'($urandom_range(0, 65535)));
        queue_read(4'd3);
        queue_read(4'd0);
        queue_read(4'd9);

        // The longest dwell: a channel is held for 256 frames before it moves.
        wait_idle();
        write_cfg(8'd1, 8'd7, 8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 8'd2);
        queue_random(300, 5);

        // Random settings per phase. Short dwells keep the scan moving; the high
        // bits of each write are random and must be dropped. Every other phase the
        // sender stops halfway until all responses are back.
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 5)),
                      {4'($urandom_range(0, 15)),
                       ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8))});
            if ($urandom_range(0, 1) == 1)
                write_unknown_reg();
            if (ph % 2 == 1) begin
                queue_random(50, 25);
                wait_idle();
                queue_random(50, 25);
            end else begin
                queue_random(100, 25);
            end
        end

        // Drain, then keep the clock running so that any stray response word can show up.
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && rsp_due.size() == 0) begin
            $display("adc_channel_scan_sequencer verification clean");
        end else begin
            $display("adc_channel_scan_sequencer verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("adc_channel_scan_sequencer verification failed");
        $finish;
    end

endmodule

// File: adc_channel_scan_sequencer.f
sv/acs_pkg.sv
sv/acs_front.sv
sv/acs_fifo.sv
sv/acs_back.sv
sv/adc_channel_scan_sequencer.sv
sim/tb_top.sv
